### rtl/lks_pkg.sv
// ---------------------------------------------------------------------------
// lks_pkg
// Shared types, character codes and helpers for the line keyword scanner.
// ---------------------------------------------------------------------------
package lks_pkg;

   // Default configuration of the scanner
   localparam int KEYWORD_CHARS_DEF = 8;
   localparam int COUNT_BITS_DEF    = 32;

   // Character codes
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;

   // Result kinds
   localparam logic KIND_KEYWORD = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_stream;
   } req_payload_type;

   typedef struct packed {
      logic        result_kind;
      logic [63:0] keyword_text;
      logic [3:0]  keyword_length;
      logic [31:0] line_number;
      logic [31:0] keywords_found;
      logic        last_of_run;
   } rsp_payload_type;

   function automatic logic is_upper(input logic [7:0] c);
      return (c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z);
   endfunction

   function automatic logic is_alnum(input logic [7:0] c);
      return is_upper(c) || ((c >= CHAR_DIGIT_0) && (c <= CHAR_DIGIT_9));
   endfunction

   // Whitespace (space, tab through CR) or NUL
   function automatic logic is_blank_nul(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_NUL) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
   endfunction

endpackage

### rtl/line_keyword_scanner_top.sv
// ---------------------------------------------------------------------------
// line_keyword_scanner_top
// Byte-stream scanner that reports uppercase keywords at line starts and an
// end-of-stream summary with newline and keyword counts.
// ---------------------------------------------------------------------------
// The scanner takes one byte per cycle while req_ready is high. Each byte is
// handled in the cycle of its transfer: the phase update, the capture write
// and the keyword check are combinational logic feeding a three-entry result
// queue. req_ready is high while the queue holds at most one result, so with
// rsp_ready held high a byte is taken every cycle and a result appears in the
// cycle after the byte that caused it. An end-of-stream item may queue two
// results (a pending keyword, then the summary) and then stalls the input
// until the queue holds at most one result again. Both counters saturate at
// 2**COUNT_BITS - 1; the result fields carry their low 32 bits. After a
// summary the scanner is back in its reset state.
module line_keyword_scanner_top #(
   parameter int KEYWORD_CHARS = lks_pkg::KEYWORD_CHARS_DEF,
   parameter int COUNT_BITS    = lks_pkg::COUNT_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  lks_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output lks_pkg::rsp_payload_type rsp_payload
);
   import lks_pkg::*;

   localparam int PosW   = $clog2(KEYWORD_CHARS + 1);
   localparam int QDepth = 3;

   typedef enum logic [2:0] {
      PH_LINE_START = 3'b001,
      PH_CAPTURE    = 3'b010,
      PH_SKIP       = 3'b100
   } phase_type;

   // Scanner state
   phase_type              phase_ff, phase_in;
   logic [PosW-1:0]        pos_ff, pos_in;
   logic [7:0]             buf_ff [KEYWORD_CHARS];
   logic [7:0]             buf_in [KEYWORD_CHARS];
   logic [COUNT_BITS-1:0]  nl_ff, nl_in, nl_inc;
   logic [COUNT_BITS-1:0]  kw_ff, kw_in, kw_inc;

   // Result queue, head at entry 0
   rsp_payload_type        q_ff [QDepth];
   rsp_payload_type        q_in [QDepth];
   logic [1:0]             q_cnt_ff, q_cnt_in, q_base;

   logic                   accept, pop;
   logic [7:0]             cur_byte;
   logic                   judge_en, summary_en, kw_hit;
   logic [3:0]             run_len;
   logic                   run_done, tail_ok;
   logic [63:0]            kw_text;
   logic [1:0]             push_n;
   rsp_payload_type        kw_res, sum_res, res0;

   assign accept    = req_valid && req_ready;
   assign pop       = rsp_valid && rsp_ready;
   assign req_ready = (q_cnt_ff <= 2'd1);
   assign rsp_valid = (q_cnt_ff != 2'd0);
   assign rsp_payload = q_ff[0];
   assign cur_byte  = req_payload.data_byte;

   // Saturating increments
   assign nl_inc = (nl_ff == {COUNT_BITS{1'b1}}) ? nl_ff : nl_ff + 1'b1;
   assign kw_inc = (kw_ff == {COUNT_BITS{1'b1}}) ? kw_ff : kw_ff + 1'b1;

   // Phase update and capture write
   always_comb begin
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      buf_in     = buf_ff;
      nl_in      = nl_ff;
      judge_en   = 1'b0;
      summary_en = 1'b0;
      if (accept) begin
         if (req_payload.end_of_stream) begin
            judge_en   = (phase_ff == PH_CAPTURE);
            summary_en = 1'b1;
            phase_in   = PH_LINE_START;
            pos_in     = '0;
            nl_in      = '0;
         end else begin
            unique case (phase_ff)
               PH_LINE_START: begin
                  if (cur_byte == CHAR_NEWLINE) begin
                     nl_in = nl_inc;
                  end else if (is_upper(cur_byte)) begin
                     for (int b = 0; b < KEYWORD_CHARS; b++) begin
                        buf_in[b] = (b == 0) ? cur_byte : CHAR_NUL;
                     end
                     pos_in   = PosW'(1);
                     phase_in = PH_CAPTURE;
                     if (KEYWORD_CHARS <= 1) begin
                        judge_en = 1'b1;
                        phase_in = PH_SKIP;
                     end
                  end else begin
                     phase_in = PH_SKIP;
                  end
               end
               PH_CAPTURE: begin
                  if (cur_byte == CHAR_NEWLINE) begin
                     judge_en = 1'b1;
                     nl_in    = nl_inc;
                     phase_in = PH_LINE_START;
                  end else if ((cur_byte == CHAR_SLASH) || (cur_byte == CHAR_NUL)) begin
                     judge_en = 1'b1;
                     phase_in = PH_SKIP;
                  end else begin
                     for (int b = 0; b < KEYWORD_CHARS; b++) begin
                        if (PosW'(b) == pos_ff) begin
                           buf_in[b] = cur_byte;
                        end
                     end
                     pos_in = pos_ff + 1'b1;
                     if (int'(pos_ff) + 1 >= KEYWORD_CHARS) begin
                        judge_en = 1'b1;
                        phase_in = PH_SKIP;
                     end
                  end
               end
               default: begin
                  // skipping the rest of a line
                  if (cur_byte == CHAR_NEWLINE) begin
                     nl_in    = nl_inc;
                     phase_in = PH_LINE_START;
                  end
               end
            endcase
         end
      end
   end

   // Keyword check on the updated capture
   always_comb begin
      run_len  = 4'(KEYWORD_CHARS);
      run_done = 1'b0;
      for (int b = 0; b < KEYWORD_CHARS; b++) begin
         if (!run_done && !is_alnum(buf_in[b])) begin
            run_len  = 4'(b);
            run_done = 1'b1;
         end
      end
      tail_ok = 1'b1;
      for (int b = 0; b < KEYWORD_CHARS; b++) begin
         if ((4'(b) >= run_len) && !is_blank_nul(buf_in[b])) begin
            tail_ok = 1'b0;
         end
      end
      kw_text = '0;
      for (int b = 0; b < KEYWORD_CHARS; b++) begin
         if (4'(b) < run_len) begin
            kw_text[8*b +: 8] = buf_in[b];
         end
      end
   end

   assign kw_hit = judge_en && tail_ok;
   assign kw_in  = summary_en ? '0 : (kw_hit ? kw_inc : kw_ff);

   // Results of this transfer
   always_comb begin
      kw_res.result_kind     = KIND_KEYWORD;
      kw_res.keyword_text    = kw_text;
      kw_res.keyword_length  = run_len;
      kw_res.line_number     = 32'(nl_ff);
      kw_res.keywords_found  = 32'(kw_inc);
      kw_res.last_of_run     = !summary_en;

      sum_res.result_kind    = KIND_SUMMARY;
      sum_res.keyword_text   = '0;
      sum_res.keyword_length = '0;
      sum_res.line_number    = 32'(nl_ff);
      sum_res.keywords_found = 32'(kw_hit ? kw_inc : kw_ff);
      sum_res.last_of_run    = 1'b1;

      res0   = kw_hit ? kw_res : sum_res;
      push_n = 2'(kw_hit) + 2'(summary_en);
   end

   // Result queue: shift on pop, append up to two entries
   always_comb begin
      q_in   = q_ff;
      q_base = q_cnt_ff;
      if (pop) begin
         for (int i = 0; i < QDepth - 1; i++) begin
            q_in[i] = q_ff[i+1];
         end
         q_base = q_cnt_ff - 2'd1;
      end
      for (int i = 0; i < QDepth; i++) begin
         if ((push_n != 2'd0) && (2'(i) == q_base)) begin
            q_in[i] = res0;
         end
         if ((push_n == 2'd2) && (2'(i) == q_base + 2'd1)) begin
            q_in[i] = sum_res;
         end
      end
      q_cnt_in = q_base + push_n;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LINE_START;
         pos_ff   <= '0;
         nl_ff    <= '0;
         kw_ff    <= '0;
         q_cnt_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         nl_ff    <= nl_in;
         kw_ff    <= kw_in;
         q_cnt_ff <= q_cnt_in;
      end
   end

   // Payload storage
   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
      q_ff   <= q_in;
   end

endmodule

### rtl/lks_checker.sv
// ---------------------------------------------------------------------------
// lks_port_checks
// Port-level checks for the line keyword scanner, bound to the top level.
// ---------------------------------------------------------------------------
module lks_port_checks (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input lks_pkg::req_payload_type req_payload,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input lks_pkg::rsp_payload_type rsp_payload
);
   import lks_pkg::*;

   // A pending result stays offered until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn before transfer");

   // A stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_payload))
      else $error("stalled result payload changed");

   // A summary carries no keyword and closes its run
   a_summary_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.result_kind == KIND_SUMMARY) |->
         (rsp_payload.keyword_text == 64'd0) && (rsp_payload.keyword_length == 4'd0) &&
         rsp_payload.last_of_run)
      else $error("malformed summary result");

   // A keyword starts with an uppercase letter and has a sane length
   a_keyword_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.result_kind == KIND_KEYWORD) |->
         (rsp_payload.keyword_length != 4'd0) && (rsp_payload.keyword_length <= 4'd8) &&
         is_upper(rsp_payload.keyword_text[7:0]) && (rsp_payload.keywords_found != 32'd0))
      else $error("malformed keyword result");

endmodule

bind line_keyword_scanner_top lks_port_checks u_lks_port_checks (.*);

### bench/lks_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lks_checker
// Watches both channels of the line keyword scanner, predicts the results of
// every byte and end-of-stream mark from its own scan state, and compares
// each result transfer field by field with the oldest predicted result.
// ---------------------------------------------------------------------------
module lks_checker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  lks_pkg::req_payload_type req_payload,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  lks_pkg::rsp_payload_type rsp_payload,
   output int                       mismatch_count,
   output int                       reports_pending,
   output int                       keywords_checked,
   output int                       summaries_checked
);
   import lks_pkg::*;

   localparam int KW_CHARS = KEYWORD_CHARS_DEF;
   localparam int SHOWN_MISMATCHES = 10;

   typedef enum logic [2:0] {
      AT_LINE_START = 3'b001,
      IN_CAPTURE    = 3'b010,
      SKIP_LINE     = 3'b100
   } scan_phase_type;

   // Predicted scanner state
   scan_phase_type phase;
   logic [3:0]     cap_pos;
   logic [7:0]     cap_buf [KW_CHARS];
   logic [31:0]    nl_count;
   logic [31:0]    kw_count;

   // Results of one transfer, then the ordered store of results still owed
   rsp_payload_type step_out [2];
   rsp_payload_type pending_reports [$];

   function automatic bit is_kw_char(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h30 && c <= 8'h39);
   endfunction

   // Allowed after the keyword run: space, tab..CR, or NUL
   function automatic bit is_pad_char(input logic [7:0] c);
      return c == 8'h20 || c == 8'h00 || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic [31:0] bump(input logic [31:0] v);
      return (v == '1) ? v : v + 32'd1;
   endfunction

   function automatic rsp_payload_type make_report(input logic kind,
                                                   input logic [63:0] text,
                                                   input logic [3:0] len);
      rsp_payload_type r;
      r.result_kind    = kind;
      r.keyword_text   = text;
      r.keyword_length = len;
      r.line_number    = nl_count;
      r.keywords_found = kw_count;
      r.last_of_run    = 1'b0;
      return r;
   endfunction

   task automatic clear_scan();
      phase    = AT_LINE_START;
      cap_pos  = '0;
      nl_count = '0;
      kw_count = '0;
      foreach (cap_buf[i]) cap_buf[i] = '0;
   endtask

   // Keyword check of the capture; an accepted one adds a result
   task automatic judge_capture(inout int n);
      int          run;
      bit          clean;
      logic [63:0] text;
      run   = 0;
      clean = 1'b1;
      text  = '0;
      while (run < KW_CHARS && is_kw_char(cap_buf[run])) run++;
      for (int j = run; j < KW_CHARS; j++)
         if (!is_pad_char(cap_buf[j])) clean = 1'b0;
      if (clean) begin
         for (int j = 0; j < run; j++) text[8*j +: 8] = cap_buf[j];
         kw_count    = bump(kw_count);
         step_out[n] = make_report(KIND_KEYWORD, text, 4'(run));
         n++;
      end
   endtask

   // Advance the scan state by one transfer and queue what it yields
   task automatic scan_byte(input req_payload_type item);
      int         n;
      logic [7:0] c;
      n = 0;
      c = item.data_byte;
      if (item.end_of_stream) begin
         if (phase == IN_CAPTURE) judge_capture(n);
         step_out[n] = make_report(KIND_SUMMARY, '0, '0);
         n++;
         clear_scan();
      end else begin
         case (phase)
            AT_LINE_START: begin
               if (c == CHAR_NEWLINE) begin
                  nl_count = bump(nl_count);
               end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
                  foreach (cap_buf[i]) cap_buf[i] = '0;
                  cap_buf[0] = c;
                  cap_pos    = 4'd1;
                  phase      = IN_CAPTURE;
                  if (cap_pos >= KW_CHARS) begin
                     judge_capture(n);
                     phase = SKIP_LINE;
                  end
               end else begin
                  phase = SKIP_LINE;
               end
            end
            IN_CAPTURE: begin
               if (c == CHAR_NEWLINE) begin
                  // keyword carries the count before this newline
                  judge_capture(n);
                  nl_count = bump(nl_count);
                  phase    = AT_LINE_START;
               end else if (c == CHAR_SLASH || c == CHAR_NUL) begin
                  judge_capture(n);
                  phase = SKIP_LINE;
               end else begin
                  cap_buf[cap_pos[2:0]] = c;
                  cap_pos = cap_pos + 4'd1;
                  if (cap_pos >= KW_CHARS) begin
                     judge_capture(n);
                     phase = SKIP_LINE;
                  end
               end
            end
            default: begin
               if (c == CHAR_NEWLINE) begin
                  nl_count = bump(nl_count);
                  phase    = AT_LINE_START;
               end
            end
         endcase
      end
      if (n > 0) step_out[n-1].last_of_run = 1'b1;
      for (int k = 0; k < n; k++) pending_reports.push_back(step_out[k]);
   endtask

   task automatic check_report(input rsp_payload_type got);
      rsp_payload_type want;
      if (got.result_kind == KIND_SUMMARY) summaries_checked++;
      else keywords_checked++;
      if (pending_reports.size() == 0) begin
         if (mismatch_count < SHOWN_MISMATCHES)
            $display({"%0t: result with none expected: ",
                      "kind=%0d text=%h len=%0d line=%0d found=%0d last=%0d"},
                     $realtime, got.result_kind, got.keyword_text, got.keyword_length,
                     got.line_number, got.keywords_found, got.last_of_run);
         mismatch_count++;
      end else begin
         want = pending_reports.pop_front();
         if (got !== want) begin
            if (mismatch_count < SHOWN_MISMATCHES) begin
               $display("%0t: result mismatch", $realtime);
               $display("   expected kind=%0d text=%h len=%0d line=%0d found=%0d last=%0d",
                        want.result_kind, want.keyword_text, want.keyword_length,
                        want.line_number, want.keywords_found, want.last_of_run);
               $display("   actual   kind=%0d text=%h len=%0d line=%0d found=%0d last=%0d",
                        got.result_kind, got.keyword_text, got.keyword_length,
                        got.line_number, got.keywords_found, got.last_of_run);
            end
            mismatch_count++;
         end
      end
   endtask

   initial begin
      mismatch_count    = 0;
      reports_pending   = 0;
      keywords_checked  = 0;
      summaries_checked = 0;
      clear_scan();
   end

   // Results first: a result never stems from a byte of the same edge
   always @(posedge clock) begin
      if (reset) begin
         clear_scan();
         pending_reports.delete();
      end else begin
         if (rsp_valid && rsp_ready) check_report(rsp_payload);
         if (req_valid && req_ready) scan_byte(req_payload);
      end
      reports_pending = pending_reports.size();
   end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the line keyword scanner: a short directed text,
// then random lines (mostly keyword-shaped, some noise, empty lines and
// end-of-stream marks) with random gaps on both channels and one long
// receiver hold-off. Checking is done by lks_checker.
// ---------------------------------------------------------------------------
module tb_top;
   import lks_pkg::*;

   localparam int ITEM_TARGET  = 800;
   localparam int HOLD_CYCLES  = 120;
   // Each byte is handled in the cycle of its transfer and results pass a
   // three-entry queue, which drains once the input stops.
   localparam int DRAIN_CYCLES = 10;
   // Longest quiet stretch in a correct run is the hold-off plus gaps
   localparam int IDLE_LIMIT   = 1000;

   localparam logic [7:0] CHAR_VT = 8'h0B;
   localparam logic [7:0] CHAR_FF = 8'h0C;

   logic            clock = 1'b0;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_payload_type rsp_payload;

   int mismatch_count;
   int reports_pending;
   int keywords_checked;
   int summaries_checked;

   int bytes_sent   = 0;
   int marks_sent   = 0;
   int idle_cycles  = 0;
   bit no_gaps      = 1'b0;
   bit hold_request = 1'b0;

   line_keyword_scanner_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   lks_checker u_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_payload       (req_payload),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_payload       (rsp_payload),
      .mismatch_count    (mismatch_count),
      .reports_pending   (reports_pending),
      .keywords_checked  (keywords_checked),
      .summaries_checked (summaries_checked)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Offer one item after a random gap and hold it until the transfer
   task automatic send_item(input logic [7:0] b, input logic eos);
      int              gap;
      req_payload_type item;
      item.data_byte     = b;
      item.end_of_stream = eos;
      gap = no_gaps ? 0 : $urandom_range(0, 5);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (eos) marks_sent++;
      else bytes_sent++;
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_item(b, 1'b0);
   endtask

   // End of stream; the data byte is don't-care, so randomize it
   task automatic send_mark();
      send_item(8'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   // Rest of a line: random bytes, then a newline
   task automatic send_tail();
      int n;
      n = $urandom_range(0, 4);
      repeat (n) send_byte(8'($urandom_range(0, 255)));
      send_byte(CHAR_NEWLINE);
   endtask

   // One random line, mostly keyword-shaped so that captures get judged
   task automatic send_line();
      int         shape;
      int         n;
      logic [7:0] pad;
      shape = $urandom_range(0, 9);
      if (shape < 6) begin
         send_byte(CHAR_UPPER_A + 8'($urandom_range(0, 25)));
         n = $urandom_range(0, 8);
         repeat (n) begin
            if ($urandom_range(0, 1))
               send_byte(CHAR_UPPER_A + 8'($urandom_range(0, 25)));
            else
               send_byte(CHAR_DIGIT_0 + 8'($urandom_range(0, 9)));
         end
         n = $urandom_range(0, 2);
         repeat (n) begin
            case ($urandom_range(0, 4))
               0: pad = CHAR_SPACE;
               1: pad = CHAR_TAB;
               2: pad = CHAR_VT;
               3: pad = CHAR_FF;
               default: pad = CHAR_CR;
            endcase
            send_byte(pad);
         end
         // occasionally spoil the capture
         if ($urandom_range(0, 3) == 0) send_byte(8'($urandom_range(0, 255)));
         case ($urandom_range(0, 9))
            0: begin
               send_mark();
               return;
            end
            1: send_byte(CHAR_SLASH);
            2: send_byte(CHAR_NUL);
            default: ;
         endcase
         send_tail();
      end else if (shape == 6) begin
         send_byte(CHAR_NEWLINE);
      end else if (shape == 7) begin
         send_byte(8'($urandom_range(0, 255)));
         send_tail();
      end else if (shape == 8) begin
         n = $urandom_range(1, 12);
         repeat (n) send_byte(8'($urandom_range(0, 255)));
      end else if ($urandom_range(0, 2) == 0) begin
         send_mark();
      end else begin
         send_byte(CHAR_NEWLINE);
      end
   endtask

   // Receiver: random gaps, plus one long hold-off on request
   initial begin : rsp_side
      int gap;
      rsp_ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            repeat (HOLD_CYCLES) begin
               @(negedge clock);
               rsp_ready <= 1'b0;
            end
         end
         gap = no_gaps ? 0 : $urandom_range(0, 5);
         repeat (gap) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
         end
         @(negedge clock);
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout after %0d cycles without a transfer", IDLE_LIMIT);
         $display("[line_keyword_scanner_top] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : req_side
      bit hold_done;
      hold_done   = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed text
      send_byte(CHAR_NEWLINE);              // empty line
      send_text("AB19\n");                  // keyword closed by newline
      send_text("QRSTUVWX");                // capture full at eight chars
      send_byte(CHAR_NEWLINE);
      send_byte(8'hFF);                     // high byte at line start
      send_byte(CHAR_NEWLINE);
      send_byte("K");                       // capture closed by NUL
      send_byte(CHAR_NUL);
      send_byte(CHAR_NEWLINE);
      send_text("Z7/");                     // capture closed by slash
      send_byte(CHAR_NEWLINE);
      send_byte("M");                       // high byte inside capture
      send_byte(8'h80);
      send_byte(CHAR_NEWLINE);
      send_text("KW");                      // keyword and summary together
      send_mark();
      send_mark();                          // summary of an empty stream

      // Random lines
      while (bytes_sent + marks_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 7) == 0) no_gaps = !no_gaps;
         if (!hold_done && bytes_sent + marks_sent >= 300) begin
            hold_request = 1'b1;
            hold_done    = 1'b1;
         end
         send_line();
      end
      @(negedge clock);
      req_valid <= 1'b0;

      wait (reports_pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d text bytes and %0d end-of-stream marks",
               bytes_sent, marks_sent);
      $display("checked %0d keyword and %0d summary results, %0d mismatches",
               keywords_checked, summaries_checked, mismatch_count);
      if (mismatch_count == 0 && reports_pending == 0) begin
         $display("[line_keyword_scanner_top] OK");
      end else begin
         $display("[line_keyword_scanner_top] ERROR");
      end
      $finish;
   end

endmodule
